@@ rtl/core/jsr_pkg.sv @@
// Package for the Jacobi stencil relaxation block.
// Holds widths, register codes, reset values and shared types; no dependencies.
package jsr_pkg;

    localparam int VALUE_BITS       = 32;
    localparam int ROW_BITS         = 16;
    localparam int OUT_COL_BITS     = 10;
    localparam int GRID_COLS_BITS   = 11;
    localparam int RES_BITS         = 63;
    localparam int CFG_INDEX_BITS   = 4;
    localparam int CFG_DATA_BITS    = 16;
    localparam int MAX_COLS_DEFAULT = 1024;

    localparam int ABS_BITS  = VALUE_BITS + 1;
    localparam int LO_BITS   = 16;
    localparam int HI_BITS   = ABS_BITS - LO_BITS;
    localparam int TERM_BITS = 2 * HI_BITS + LO_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS = CFG_INDEX_BITS'(1);

    localparam logic [ROW_BITS-1:0]       RESET_GRID_ROWS = ROW_BITS'(256);
    localparam logic [GRID_COLS_BITS-1:0] RESET_GRID_COLS = GRID_COLS_BITS'(256);

    localparam logic [RES_BITS-1:0] RES_MAX = '1;

    typedef logic [VALUE_BITS-1:0] t_val;

    typedef struct packed {
        t_val top;
        t_val mid;
        t_val bot;
    } t_col;

    typedef struct packed {
        logic                    emit;
        logic                    last;
        logic [ROW_BITS-1:0]     row;
        logic [OUT_COL_BITS-1:0] col;
    } t_meta;

endpackage

@@ rtl/core/jsr_ifs.sv @@
// Channel interfaces for the Jacobi stencil relaxation block.
// Cell input, result output and configuration write; depends on jsr_pkg.
interface jsr_cell_if import jsr_pkg::*; ();
    logic valid;
    logic ready;
    t_val cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

interface jsr_result_if import jsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_val                    new_value;
    logic [ROW_BITS-1:0]     out_row;
    logic [OUT_COL_BITS-1:0] out_col;
    logic [RES_BITS-1:0]     residual;
    logic                    last_point;

    modport source (output valid, output new_value, output out_row, output out_col,
                    output residual, output last_point, input ready);
    modport sink (input valid, input new_value, input out_row, input out_col,
                  input residual, input last_point, output ready);
endinterface

interface jsr_cfg_if import jsr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/jsr_line_buf.sv @@
// Row line buffer: one write port, one registered read port.
// Depends on jsr_pkg for the word type.
module jsr_line_buf import jsr_pkg::*; #(
    parameter int DEPTH = MAX_COLS_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_val          o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_val          i_wr_data
);

    t_val r_mem [DEPTH];
    t_val r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/jsr_win_cell.sv @@
// One column of the 3x3 stencil window; loads its input column when enabled.
// Depends on jsr_pkg for the column type.
module jsr_win_cell import jsr_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_col i_col,
    output t_col o_col
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

@@ rtl/core/jacobi_stencil_relaxation.sv @@
// Jacobi five-point relaxation over a raster-order grid stream.
// Throughput: one cell per cycle while no output word waits; each line buffer takes one
// read and one write per cell. Path: input register, window, sum, difference, absolute
// value, partial products, square term, output; all pipeline stages stall together.
// Reset (i_rst_n low, synchronous): counters, residual and valid bits clear, grid size
// returns to 256 x 256; line buffer contents stay undefined until written.
module jacobi_stencil_relaxation import jsr_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
    input logic          i_clk,
    input logic          i_rst_n,
    jsr_cell_if.sink     i_cell,
    jsr_result_if.source o_out,
    jsr_cfg_if.sink      i_cfg
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CCW = (CW + 1 > GRID_COLS_BITS) ? CW + 1 : GRID_COLS_BITS;
    localparam logic [CCW-1:0] COLS_CAP = CCW'(MAX_COLS);

    logic [ROW_BITS-1:0]       r_grid_rows;
    logic [GRID_COLS_BITS-1:0] r_grid_cols;
    logic [ROW_BITS-1:0]       r_row_cnt;
    logic [CW-1:0]             r_col_cnt;

    logic [ROW_BITS-1:0]       w_rows_eff;
    logic [ROW_BITS-1:0]       w_rows_m1;
    logic [GRID_COLS_BITS-1:0] w_cols_min;
    logic [CCW-1:0]            w_cols_ext;
    logic [CCW-1:0]            w_cols_m1;
    logic [CCW-1:0]            w_col_ext;
    logic                      w_row_end;
    logic                      w_col_end;
    logic                      w_adv;
    logic                      w_fire;
    t_meta                     n_meta0;

    logic [7:1] r_vld;
    t_meta      r_meta [1:7];

    t_val          r_p1_v;
    logic [CW-1:0] r_p1_c;
    t_val          w_rd_a;
    t_val          w_rd_b;
    t_col          w_col [3];
    t_col          w_col_in [3];

    logic [VALUE_BITS+1:0]    n_sum;
    logic [VALUE_BITS+1:0]    r_p3_sum;
    t_val                     r_p3_ctr;
    logic [VALUE_BITS:0]      n_d;
    t_val                     r_p4_nv;
    logic [VALUE_BITS:0]      r_p4_d;
    logic [ABS_BITS-1:0]      n_abs;
    t_val                     r_p5_nv;
    logic [ABS_BITS-1:0]      r_p5_abs;
    logic [HI_BITS-1:0]       w_hi;
    logic [LO_BITS-1:0]       w_lo;
    logic [2*HI_BITS-1:0]     n_hh;
    logic [HI_BITS+LO_BITS-1:0] n_hl;
    logic [2*LO_BITS-1:0]     n_ll;
    t_val                     r_p6_nv;
    logic [2*HI_BITS-1:0]     r_p6_hh;
    logic [HI_BITS+LO_BITS-1:0] r_p6_hl;
    logic [2*LO_BITS-1:0]     r_p6_ll;
    logic [TERM_BITS-1:0]     n_term;
    t_val                     r_p7_nv;
    logic [TERM_BITS-1:0]     r_p7_term;
    logic [RES_BITS:0]        n_res_sum;
    logic [RES_BITS-1:0]      n_res;
    logic [RES_BITS-1:0]      r_acc;

    logic                    r_out_valid;
    t_val                    r_out_value;
    logic [ROW_BITS-1:0]     r_out_row;
    logic [OUT_COL_BITS-1:0] r_out_col;
    logic [RES_BITS-1:0]     r_out_res;
    logic                    r_out_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= RESET_GRID_ROWS;
            r_grid_cols <= RESET_GRID_COLS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GRID_ROWS: r_grid_rows <= i_cfg.data[ROW_BITS-1:0];
                REG_GRID_COLS: r_grid_cols <= i_cfg.data[GRID_COLS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv        = !r_out_valid || o_out.ready;
    assign w_fire       = i_cell.valid && w_adv;
    assign i_cell.ready = w_adv;

    always_comb begin
        w_rows_eff = (r_grid_rows < ROW_BITS'(3)) ? ROW_BITS'(3) : r_grid_rows;
        w_rows_m1  = w_rows_eff - ROW_BITS'(1);
        w_cols_min = (r_grid_cols < GRID_COLS_BITS'(3)) ? GRID_COLS_BITS'(3) : r_grid_cols;
        w_cols_ext = CCW'(w_cols_min);
        w_cols_m1  = ((w_cols_ext > COLS_CAP) ? COLS_CAP : w_cols_ext) - CCW'(1);
        w_col_ext  = CCW'(r_col_cnt);
        w_row_end  = r_row_cnt >= w_rows_m1;
        w_col_end  = w_col_ext >= w_cols_m1;
        n_meta0.emit = (r_row_cnt >= ROW_BITS'(2)) && (w_col_ext >= CCW'(2));
        n_meta0.last = w_row_end && w_col_end;
        n_meta0.row  = r_row_cnt - ROW_BITS'(1);
        n_meta0.col  = OUT_COL_BITS'(w_col_ext - CCW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (w_fire) begin
            if (w_col_end) begin
                r_col_cnt <= '0;
                r_row_cnt <= w_row_end ? '0 : r_row_cnt + ROW_BITS'(1);
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    jsr_line_buf #(.DEPTH(MAX_COLS)) u_buf_a (
        .i_clk     (i_clk),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_col_cnt),
        .o_rd_data (w_rd_a),
        .i_wr_en   (w_adv && r_vld[1]),
        .i_wr_addr (r_p1_c),
        .i_wr_data (r_p1_v)
    );

    jsr_line_buf #(.DEPTH(MAX_COLS)) u_buf_b (
        .i_clk     (i_clk),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_col_cnt),
        .o_rd_data (w_rd_b),
        .i_wr_en   (w_adv && r_vld[1]),
        .i_wr_addr (r_p1_c),
        .i_wr_data (w_rd_a)
    );

    assign w_col_in[2] = '{top: w_rd_b, mid: w_rd_a, bot: r_p1_v};
    assign w_col_in[1] = w_col[2];
    assign w_col_in[0] = w_col[1];

    for (genvar g = 0; g < 3; g++) begin : g_win
        jsr_win_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv && r_vld[1]),
            .i_col (w_col_in[g]),
            .o_col (w_col[g])
        );
    end

    always_comb begin
        n_sum = {{2{w_col[0].mid[VALUE_BITS-1]}}, w_col[0].mid}
              + {{2{w_col[2].mid[VALUE_BITS-1]}}, w_col[2].mid}
              + {{2{w_col[1].top[VALUE_BITS-1]}}, w_col[1].top}
              + {{2{w_col[1].bot[VALUE_BITS-1]}}, w_col[1].bot};
        n_d   = {r_p3_sum[VALUE_BITS+1], r_p3_sum[VALUE_BITS+1:2]}
              - {r_p3_ctr[VALUE_BITS-1], r_p3_ctr};
        n_abs = r_p4_d[VALUE_BITS] ? (~r_p4_d + ABS_BITS'(1)) : r_p4_d;
        w_hi  = r_p5_abs[ABS_BITS-1:LO_BITS];
        w_lo  = r_p5_abs[LO_BITS-1:0];
        n_hh  = w_hi * w_hi;
        n_hl  = w_hi * w_lo;
        n_ll  = w_lo * w_lo;
        n_term = {r_p6_hh, {LO_BITS{1'b0}}}
               + TERM_BITS'({r_p6_hl, 1'b0})
               + TERM_BITS'(r_p6_ll[2*LO_BITS-1:LO_BITS]);
        n_res_sum = {1'b0, r_acc} + (RES_BITS+1)'(r_p7_term);
        n_res     = n_res_sum[RES_BITS] ? RES_MAX : n_res_sum[RES_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[6:1], i_cell.valid};
            r_out_valid <= r_vld[7] && r_meta[7].emit;
            if (r_vld[7]) begin
                if (r_meta[7].last) begin
                    r_acc <= '0;
                end else if (r_meta[7].emit) begin
                    r_acc <= n_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_v    <= i_cell.cell_value;
            r_p1_c    <= r_col_cnt;
            r_meta[1] <= n_meta0;
            for (int k = 2; k <= 7; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
            r_p3_sum    <= n_sum;
            r_p3_ctr    <= w_col[1].mid;
            r_p4_nv     <= r_p3_sum[VALUE_BITS+1:2];
            r_p4_d      <= n_d;
            r_p5_nv     <= r_p4_nv;
            r_p5_abs    <= n_abs;
            r_p6_nv     <= r_p5_nv;
            r_p6_hh     <= n_hh;
            r_p6_hl     <= n_hl;
            r_p6_ll     <= n_ll;
            r_p7_nv     <= r_p6_nv;
            r_p7_term   <= n_term;
            r_out_value <= r_p7_nv;
            r_out_row   <= r_meta[7].row;
            r_out_col   <= r_meta[7].col;
            r_out_res   <= n_res;
            r_out_last  <= r_meta[7].last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.new_value  = r_out_value;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.residual   = r_out_res;
    assign o_out.last_point = r_out_last;

`ifndef NO_ASSERTIONS
    a_stall_only_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cell.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a waiting output word");

    a_buf_addr_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[1]) |-> (r_col_cnt != r_p1_c))
        else $error("line buffer read and write hit the same column");

    a_res_clear_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[7] && r_meta[7].last) |=> (r_acc == '0))
        else $error("residual not cleared after frame end");

    a_interior_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.out_row != '0))
        else $error("result word on a border row");
`endif

endmodule
